/* sv/rar_pkg.sv */
`default_nettype none
package rar_pkg;

  localparam int unsigned OPERAND_W = 16;
  localparam int unsigned NUM_W     = 2 * OPERAND_W + 1;
  localparam int unsigned DEN_W     = 2 * OPERAND_W;
  localparam int unsigned PROD_W    = 2 * OPERAND_W;
  // wide enough for the trailing-zero count (at most DEN_W) and the step counter
  localparam int unsigned CNT_W     = $clog2(NUM_W + 1);

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [OPERAND_W-1:0] a_num;
    logic [OPERAND_W-1:0] a_den;
    logic [OPERAND_W-1:0] b_num;
    logic [OPERAND_W-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic [NUM_W-1:0] res_num;
    logic [DEN_W-1:0] res_den;
    logic             is_empty;
  } out_t;

  // multiplier operand pair
  typedef enum logic [1:0] {
    MS_AD_BD = 2'd0,
    MS_AN_X  = 2'd1,
    MS_AD_BN = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     ld_in;
    mul_sel_t mul_sel;
    logic     ld_den;
    logic     ld_num;
    logic     acc_num;
    logic     ld_uv;
    logic     gcd_shift;
    logic     gcd_step;
    logic     ld_div;
    logic     div_step;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic in_empty;
    logic both_even;
    logic v_zero;
  } sts_t;

endpackage
`default_nettype wire

/* sv/rational_add_mul_reduce.sv */
`default_nettype none
// Rational add/multiply with reduction to lowest terms. A request carries two
// fractions a_num/a_den and b_num/b_den plus a mode (add or multiply); the
// result is the sum or product reduced by the gcd of numerator and denominator,
// in fields wide enough that nothing overflows. A fraction with a zero
// numerator or denominator is empty, and any empty operand gives 0/0 with
// is_empty set. One request is in flight at a time. A non-empty request first
// uses the shared 16x16 multiplier, then runs a binary gcd of one
// compare-and-subtract or shift per cycle (data dependent, in a twos-stripping
// loop and then a subtract loop), then restoring division that divides
// numerator and denominator side by side, then loads the output register.
// An empty request skips all of that and goes straight to loading the
// output register. The result sits in an output register, so a new request
// is taken while it waits.
module rational_add_mul_reduce (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // request channel
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rar_pkg::in_t  in_data,
  // result channel
  output logic               out_valid,
  input  wire logic          out_ready,
  output rar_pkg::out_t      out_data
);

  rar_pkg::cmd_t cmd;
  rar_pkg::sts_t sts;

  // sequencer: multiply schedule, gcd loop control, divide count, output hold
  rar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // operand registers, multiplier, gcd registers, two dividers, result register
  rar_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

/* sv/rar_datapath.sv */
`default_nettype none
module rar_datapath (
  input  wire logic         clk,
  input  wire rar_pkg::in_t in_data,
  input  wire rar_pkg::cmd_t cmd,
  output rar_pkg::sts_t     sts,
  output rar_pkg::out_t     out_data
);

  localparam int unsigned W  = rar_pkg::OPERAND_W;
  localparam int unsigned NW = rar_pkg::NUM_W;
  localparam int unsigned DW = rar_pkg::DEN_W;
  localparam int unsigned PW = rar_pkg::PROD_W;
  localparam int unsigned CW = rar_pkg::CNT_W;

  logic          mode_r;
  logic [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic          empty_r;
  logic [PW-1:0] prod_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] u_r, v_r;
  logic [CW-1:0] k_r;
  logic [NW-1:0] dvs_r;
  logic [NW-1:0] qn_r, qd_r;
  logic [NW-1:0] rn_r, rd_r;
  rar_pkg::out_t out_r;

  logic [W-1:0]  mul_a, mul_b;
  logic [NW:0]   rn_try, rd_try;
  logic          rn_ge, rd_ge;

  assign sts.in_empty  = (in_data.a_num == '0) || (in_data.a_den == '0) ||
                         (in_data.b_num == '0) || (in_data.b_den == '0);
  assign sts.both_even = !u_r[0] && !v_r[0];
  assign sts.v_zero    = (v_r == '0);
  assign out_data      = out_r;

  always_comb begin
    case (cmd.mul_sel)
      rar_pkg::MS_AD_BD: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
      rar_pkg::MS_AN_X: begin
        mul_a = an_r;
        mul_b = (mode_r == rar_pkg::MODE_MUL) ? bn_r : bd_r;
      end
      rar_pkg::MS_AD_BN: begin
        mul_a = ad_r;
        mul_b = bn_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
  end

  // restoring divide trial: shift in next dividend bit, compare with divisor
  assign rn_try = {rn_r, qn_r[NW-1]};
  assign rd_try = {rd_r, qd_r[NW-1]};
  assign rn_ge  = rn_try >= {1'b0, dvs_r};
  assign rd_ge  = rd_try >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);

    if (cmd.ld_in) begin
      mode_r  <= in_data.mode;
      an_r    <= in_data.a_num;
      ad_r    <= in_data.a_den;
      bn_r    <= in_data.b_num;
      bd_r    <= in_data.b_den;
      empty_r <= sts.in_empty;
    end

    if (cmd.ld_den)
      den_r <= prod_r;
    if (cmd.ld_num)
      num_r <= NW'(prod_r);
    else if (cmd.acc_num && (mode_r == rar_pkg::MODE_ADD))
      num_r <= num_r + NW'(prod_r);

    // binary gcd: strip common twos, then halve even values and subtract odd ones
    if (cmd.ld_uv) begin
      u_r <= num_r;
      v_r <= NW'(den_r);
      k_r <= '0;
    end else if (cmd.gcd_shift) begin
      u_r <= u_r >> 1;
      v_r <= v_r >> 1;
      k_r <= k_r + CW'(1);
    end else if (cmd.gcd_step) begin
      if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r > v_r) begin
        u_r <= v_r;
        v_r <= u_r - v_r;
      end else begin
        v_r <= v_r - u_r;
      end
    end

    // g = u << k, so x / g = (x >> k) / u exactly
    if (cmd.ld_div) begin
      qn_r  <= num_r >> k_r;
      qd_r  <= NW'(den_r) >> k_r;
      rn_r  <= '0;
      rd_r  <= '0;
      dvs_r <= u_r;
    end else if (cmd.div_step) begin
      rn_r <= rn_ge ? NW'(rn_try - {1'b0, dvs_r}) : NW'(rn_try);
      rd_r <= rd_ge ? NW'(rd_try - {1'b0, dvs_r}) : NW'(rd_try);
      qn_r <= {qn_r[NW-2:0], rn_ge};
      qd_r <= {qd_r[NW-2:0], rd_ge};
    end

    if (cmd.ld_out) begin
      if (empty_r) begin
        out_r.res_num  <= '0;
        out_r.res_den  <= '0;
        out_r.is_empty <= 1'b1;
      end else begin
        out_r.res_num  <= qn_r;
        out_r.res_den  <= qd_r[DW-1:0];
        out_r.is_empty <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/rar_ctrl.sv */
`default_nettype none
module rar_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire rar_pkg::sts_t sts,
  output rar_pkg::cmd_t      cmd
);

  localparam int unsigned CW = rar_pkg::CNT_W;
  localparam logic [CW-1:0] MUL_LAST = CW'(4);
  localparam logic [CW-1:0] DIV_LAST = CW'(rar_pkg::NUM_W - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_GSHIFT = 6'b000100,
    ST_GRUN   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mul_sel = rar_pkg::MS_AD_BD;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sts.in_empty ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + CW'(1);
        case (cnt_r)
          CW'(0): cmd.mul_sel = rar_pkg::MS_AD_BD;
          CW'(1): begin
            cmd.mul_sel = rar_pkg::MS_AN_X;
            cmd.ld_den  = 1'b1;
          end
          CW'(2): begin
            cmd.mul_sel = rar_pkg::MS_AD_BN;
            cmd.ld_num  = 1'b1;
          end
          CW'(3): cmd.acc_num = 1'b1;
          default: begin
            cmd.ld_uv = 1'b1;
          end
        endcase
        if (cnt_r == MUL_LAST)
          state_nxt = ST_GSHIFT;
      end
      ST_GSHIFT: begin
        if (sts.both_even)
          cmd.gcd_shift = 1'b1;
        else
          state_nxt = ST_GRUN;
      end
      ST_GRUN: begin
        if (sts.v_zero) begin
          cmd.ld_div = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == DIV_LAST)
          state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/rar_chk.sv */
`default_nettype none
module rar_chk (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire rar_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire rar_pkg::out_t out_data
);

  // waiting request stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request dropped or changed while waiting");

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      (out_data.res_num == '0) && (out_data.res_den == '0))
    else $error("empty result not 0/0");

  a_full_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_empty |->
      (out_data.res_num != '0) && (out_data.res_den != '0))
    else $error("non-empty result has a zero field");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind rational_add_mul_reduce rar_chk u_rar_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
